// ===== rtl/nfts_pkg.sv =====
// Shared types, constants and codes for the named file table store.
`timescale 1ns / 1ps
package nfts_pkg;

  localparam int MAX_FILES = 8;
  localparam int NAME_MAX  = 8;
  localparam int DATA_MAX  = 64;

  localparam int SLOT_W   = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int SCAN_W   = SLOT_W + 1;
  localparam int POS_W    = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;
  localparam int REC_AW   = SLOT_W + POS_W;
  localparam int REC_DEPTH = MAX_FILES * DATA_MAX;
  localparam int CNT_W    = 6;
  localparam int KEY_W    = 64;
  localparam int KEY_BYTES = KEY_W / 8;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NAME_LONG  = 3'd1;
  localparam logic [2:0] ST_LEN_LONG   = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_BAD_MAXLEN = 3'd5;
  localparam logic [2:0] ST_UNEXPECTED = 3'd6;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SEL,
    S_RD_REQ,
    S_RD_DATA,
    S_STATUS
  } ctrl_state_t;

  typedef struct packed {
    action_t      action;
    logic [63:0]  name_key;
    logic [7:0]   length;
    logic [7:0]   max_len;
    logic [7:0]   data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [5:0]  byte_count;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] name;
    logic [CNT_W-1:0] len;
  } slot_ent_t;

  localparam int SLOT_ENT_W = $bits(slot_ent_t);

  typedef struct packed {
    logic      load;
    out_item_t item;
  } out_load_t;

endpackage

// ===== rtl/named_file_table_store_top.sv =====
// Top level of the named file table store: sequencer, slot and record memories, output register.
`timescale 1ns / 1ps
// The block keeps eight named records of up to 63 bytes. Names and lengths sit in an
// eight-entry slot memory and the record bytes in a 512-byte record memory; per-slot
// used bits are flip-flops, so no clearing pass follows reset. One item is handled at
// a time. A write start or a read passes through accept, decode, a name search that
// reads one slot per cycle over the slot memory port, and slot selection, plus a status
// transaction where it produces one. A data byte is accepted and decoded, with a status
// transaction when it completes the record or finds no open write. A clear, or a write
// start or read rejected before the search, is accepted, decoded and closed by a status
// transaction. A read returns each byte through a request and a data state, around the
// registered read of the record memory, and a status transaction closes every item that
// produces results. Every result step stretches for as long as the output register is
// held by a stall. A finished result waits in the output register while the next item is accepted.
module named_file_table_store_top
  (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nfts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nfts_pkg::out_item_t out_data
);
  import nfts_pkg::*;

  logic                 slot_we;
  logic [SLOT_W-1:0]    slot_waddr;
  slot_ent_t            slot_wdata;
  logic                 slot_re;
  logic [SLOT_W-1:0]    slot_raddr;
  logic [SLOT_ENT_W-1:0] slot_rdata_bits;
  slot_ent_t            slot_rdata;
  logic                 rec_we;
  logic [REC_AW-1:0]    rec_waddr;
  logic [7:0]           rec_wdata;
  logic                 rec_re;
  logic [REC_AW-1:0]    rec_raddr;
  logic [7:0]           rec_rdata;
  logic                 out_free;
  out_load_t            ld;

  assign slot_rdata = slot_ent_t'(slot_rdata_bits);

  nfts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .slot_we    (slot_we),
    .slot_waddr (slot_waddr),
    .slot_wdata (slot_wdata),
    .slot_re    (slot_re),
    .slot_raddr (slot_raddr),
    .slot_rdata (slot_rdata),
    .rec_we     (rec_we),
    .rec_waddr  (rec_waddr),
    .rec_wdata  (rec_wdata),
    .rec_re     (rec_re),
    .rec_raddr  (rec_raddr),
    .rec_rdata  (rec_rdata),
    .out_free   (out_free),
    .ld         (ld)
  );

  nfts_ram #(
    .WIDTH (SLOT_ENT_W),
    .DEPTH (MAX_FILES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (SLOT_ENT_W'(slot_wdata)),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata_bits)
  );

  nfts_ram #(
    .WIDTH (8),
    .DEPTH (REC_DEPTH)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .re    (rec_re),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  nfts_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/nfts_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module nfts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nfts_outreg.sv =====
// Output register that holds one result transaction while the sink stalls.
`timescale 1ns / 1ps
module nfts_outreg
  (
  input  logic                clk,
  input  logic                rst_n,
  input  nfts_pkg::out_load_t ld,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output nfts_pkg::out_item_t out_data
);
  import nfts_pkg::*;

  logic      out_valid_r;
  out_item_t out_item_r;

  assign free      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      out_item_r <= ld.item;
    end
  end

endmodule

// ===== rtl/nfts_ctrl.sv =====
// Sequencer that decodes items, searches the slot table and drives both memories.
`timescale 1ns / 1ps
module nfts_ctrl
  (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nfts_pkg::in_item_t                in_data,
  output logic                              slot_we,
  output logic [nfts_pkg::SLOT_W-1:0]       slot_waddr,
  output nfts_pkg::slot_ent_t               slot_wdata,
  output logic                              slot_re,
  output logic [nfts_pkg::SLOT_W-1:0]       slot_raddr,
  input  nfts_pkg::slot_ent_t               slot_rdata,
  output logic                              rec_we,
  output logic [nfts_pkg::REC_AW-1:0]       rec_waddr,
  output logic [7:0]                        rec_wdata,
  output logic                              rec_re,
  output logic [nfts_pkg::REC_AW-1:0]       rec_raddr,
  input  logic [7:0]                        rec_rdata,
  input  logic                              out_free,
  output nfts_pkg::out_load_t               ld
);
  import nfts_pkg::*;

  ctrl_state_t state_r, state_nxt;

  action_t            act_r, act_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic               too_long_r, too_long_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [7:0]         maxl_r, maxl_nxt;
  logic [7:0]         dbyte_r, dbyte_nxt;

  logic [MAX_FILES-1:0] used_r, used_nxt;
  logic                 wopen_r, wopen_nxt;
  logic [SLOT_W-1:0]    wslot_r, wslot_nxt;
  logic [CNT_W-1:0]     wpos_r, wpos_nxt;
  logic [CNT_W-1:0]     wrem_r, wrem_nxt;
  logic [KEY_W-1:0]     wname_r, wname_nxt;

  logic [SCAN_W-1:0]    scan_r, scan_nxt;
  logic                 found_r, found_nxt;
  logic [SLOT_W-1:0]    fslot_r, fslot_nxt;
  logic [CNT_W-1:0]     flen_r, flen_nxt;
  logic [CNT_W-1:0]     rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0]     rnum_r, rnum_nxt;
  logic [2:0]           stc_r, stc_nxt;
  logic [CNT_W-1:0]     stn_r, stn_nxt;

  logic [KEY_W-1:0]     norm_key;
  logic                 norm_long;
  logic [SLOT_W-1:0]    cmp_idx;
  logic                 hit;
  logic                 scan_done;
  logic                 free_any;
  logic [SLOT_W-1:0]    free_idx;
  logic [SLOT_W-1:0]    sel_slot;
  logic [7:0]           ml1;
  logic [CNT_W-1:0]     rd_n;
  logic [CNT_W-1:0]     rcnt_inc;
  logic                 accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic alive;
    logic [7:0] b;
    alive     = 1'b1;
    norm_key  = '0;
    norm_long = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = in_data.name_key[8*i +: 8];
      alive = alive && (b != 8'd0);
      if (alive) begin
        norm_key[8*i +: 8] = b;
      end
      if (i == NAME_MAX - 1) begin
        norm_long = alive;
      end
    end
  end

  assign cmp_idx   = SLOT_W'(scan_r - SCAN_W'(1));
  assign scan_done = (scan_r == SCAN_W'(MAX_FILES));
  assign hit       = (scan_r != '0) && used_r[cmp_idx] && (slot_rdata.name == key_r);

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_FILES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign sel_slot = found_r ? fslot_r : free_idx;
  assign ml1      = maxl_r - 8'd1;
  assign rd_n     = (ml1 < {2'b00, flen_r}) ? ml1[CNT_W-1:0] : flen_r;
  assign rcnt_inc = rcnt_r + CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (act_r)
          ACT_START: state_nxt = (too_long_r || len_r >= 8'(DATA_MAX)) ? S_STATUS : S_SEARCH;
          ACT_DATA:  state_nxt = (!wopen_r || wrem_r == CNT_W'(1)) ? S_STATUS : S_IDLE;
          ACT_READ:  state_nxt = (maxl_r == 8'd0) ? S_STATUS : S_SEARCH;
          ACT_CLEAR: state_nxt = S_STATUS;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_SEARCH: begin
        if (hit || scan_done) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (act_r == ACT_START) begin
          state_nxt = (!found_r && !free_any) ? S_STATUS :
                      (len_r == 8'd0) ? S_STATUS : S_IDLE;
        end else begin
          state_nxt = (!found_r || rd_n == '0) ? S_STATUS : S_RD_REQ;
        end
      end
      S_RD_REQ: state_nxt = S_RD_DATA;
      S_RD_DATA: begin
        if (out_free) begin
          state_nxt = (rcnt_inc == rnum_r) ? S_STATUS : S_RD_REQ;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    act_nxt      = act_r;
    key_nxt      = key_r;
    too_long_nxt = too_long_r;
    len_nxt      = len_r;
    maxl_nxt     = maxl_r;
    dbyte_nxt    = dbyte_r;
    used_nxt     = used_r;
    wopen_nxt    = wopen_r;
    wslot_nxt    = wslot_r;
    wpos_nxt     = wpos_r;
    wrem_nxt     = wrem_r;
    wname_nxt    = wname_r;
    scan_nxt     = scan_r;
    found_nxt    = found_r;
    fslot_nxt    = fslot_r;
    flen_nxt     = flen_r;
    rcnt_nxt     = rcnt_r;
    rnum_nxt     = rnum_r;
    stc_nxt      = stc_r;
    stn_nxt      = stn_r;
    slot_we      = 1'b0;
    slot_waddr   = '0;
    slot_wdata   = '0;
    slot_re      = 1'b0;
    slot_raddr   = scan_r[SLOT_W-1:0];
    rec_we       = 1'b0;
    rec_waddr    = {wslot_r, wpos_r[POS_W-1:0]};
    rec_wdata    = dbyte_r;
    rec_re       = 1'b0;
    rec_raddr    = {fslot_r, rcnt_r[POS_W-1:0]};
    ld           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt      = in_data.action;
          key_nxt      = norm_key;
          too_long_nxt = norm_long;
          len_nxt      = in_data.length;
          maxl_nxt     = in_data.max_len;
          dbyte_nxt    = in_data.data_byte;
        end
      end
      S_DECODE: begin
        scan_nxt  = '0;
        found_nxt = 1'b0;
        stn_nxt   = '0;
        stc_nxt   = ST_OK;
        unique case (act_r)
          ACT_START: begin
            wopen_nxt = 1'b0;
            if (too_long_r) begin
              stc_nxt = ST_NAME_LONG;
            end else if (len_r >= 8'(DATA_MAX)) begin
              stc_nxt = ST_LEN_LONG;
            end
          end
          ACT_DATA: begin
            if (!wopen_r) begin
              stc_nxt = ST_UNEXPECTED;
            end else begin
              rec_we   = 1'b1;
              wpos_nxt = wpos_r + CNT_W'(1);
              wrem_nxt = wrem_r - CNT_W'(1);
              if (wrem_r == CNT_W'(1)) begin
                wopen_nxt         = 1'b0;
                used_nxt[wslot_r] = 1'b1;
                slot_we           = 1'b1;
                slot_waddr        = wslot_r;
                slot_wdata.name   = wname_r;
                slot_wdata.len    = wpos_r + CNT_W'(1);
                stn_nxt           = wpos_r + CNT_W'(1);
              end
            end
          end
          ACT_READ: begin
            if (maxl_r == 8'd0) begin
              stc_nxt = ST_BAD_MAXLEN;
            end
          end
          ACT_CLEAR: begin
            used_nxt  = '0;
            wopen_nxt = 1'b0;
            wslot_nxt = '0;
            wpos_nxt  = '0;
            wrem_nxt  = '0;
          end
          default: begin
          end
        endcase
      end
      S_SEARCH: begin
        slot_re = !scan_done;
        if (hit) begin
          found_nxt = 1'b1;
          fslot_nxt = cmp_idx;
          flen_nxt  = slot_rdata.len;
        end else if (!scan_done) begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
      end
      S_SEL: begin
        stn_nxt = '0;
        stc_nxt = ST_OK;
        rcnt_nxt = '0;
        if (act_r == ACT_START) begin
          if (!found_r && !free_any) begin
            stc_nxt = ST_FULL;
          end else begin
            slot_we         = 1'b1;
            slot_waddr      = sel_slot;
            slot_wdata.name = key_r;
            slot_wdata.len  = found_r ? flen_r : '0;
            if (len_r == 8'd0) begin
              used_nxt[sel_slot] = 1'b1;
              slot_wdata.len     = '0;
            end else begin
              wopen_nxt = 1'b1;
              wslot_nxt = sel_slot;
              wpos_nxt  = '0;
              wrem_nxt  = len_r[CNT_W-1:0];
              wname_nxt = key_r;
            end
          end
        end else begin
          if (!found_r) begin
            stc_nxt = ST_NOT_FOUND;
          end else begin
            rnum_nxt = rd_n;
            stn_nxt  = rd_n;
          end
        end
      end
      S_RD_REQ: begin
        rec_re = 1'b1;
      end
      S_RD_DATA: begin
        if (out_free) begin
          ld.load            = 1'b1;
          ld.item.kind       = KIND_DATA;
          ld.item.out_byte   = rec_rdata;
          ld.item.byte_count = '0;
          ld.item.status     = ST_OK;
          ld.item.last       = 1'b0;
          rcnt_nxt           = rcnt_inc;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          ld.load            = 1'b1;
          ld.item.kind       = KIND_STATUS;
          ld.item.out_byte   = '0;
          ld.item.byte_count = stn_r;
          ld.item.status     = stc_r;
          ld.item.last       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      wopen_r <= 1'b0;
      wslot_r <= '0;
      wpos_r  <= '0;
      wrem_r  <= '0;
      scan_r  <= '0;
      found_r <= 1'b0;
      rcnt_r  <= '0;
      rnum_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      wopen_r <= wopen_nxt;
      wslot_r <= wslot_nxt;
      wpos_r  <= wpos_nxt;
      wrem_r  <= wrem_nxt;
      scan_r  <= scan_nxt;
      found_r <= found_nxt;
      rcnt_r  <= rcnt_nxt;
      rnum_r  <= rnum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    too_long_r <= too_long_nxt;
    len_r      <= len_nxt;
    maxl_r     <= maxl_nxt;
    dbyte_r    <= dbyte_nxt;
    wname_r    <= wname_nxt;
    fslot_r    <= fslot_nxt;
    flen_r     <= flen_nxt;
    stc_r      <= stc_nxt;
    stn_r      <= stn_nxt;
  end

endmodule

// ===== dv/named_file_table_store_top_tb.sv =====
// Testbench for the named file table store: directed and random transactions checked against a predictor.
`timescale 1ns / 1ps
module named_file_table_store_top_tb;
  import nfts_pkg::*;

  localparam logic [63:0] KEY_EMPTY = 64'h0;
  localparam logic [63:0] KEY_A     = 64'h61;
  localparam logic [63:0] KEY_B     = 64'h007F_8091_A2B3_C4D5;
  localparam logic [63:0] KEY_C     = 64'h63;
  localparam logic [63:0] KEY_D     = 64'h64;
  localparam logic [63:0] KEY_LONG  = 64'h0043_4552_474E_4F4C;
  localparam logic [63:0] KEY_OVER  = 64'hFFFF_FFFF_FFFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  bit                 held [MAX_FILES];
  logic [KEY_W-1:0]   held_key [MAX_FILES];
  logic [CNT_W-1:0]   held_len [MAX_FILES];
  logic [7:0]         rec_mem [MAX_FILES][DATA_MAX];
  bit                 wr_busy;
  int                 wr_idx;
  int                 wr_at;
  int                 wr_left;

  out_item_t results_due [$];
  out_item_t next_due;
  int        mismatch_count = 0;
  bit        src_idle_en = 1'b1;
  bit        snk_idle_en = 1'b1;
  int        sink_wait_left = 0;
  int        hold_cycles_left = 0;

  named_file_table_store_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("%0t ns: mismatch, %s", $time, what);
    end
  endtask

  function automatic void queue_status(input logic [2:0] st, input int cnt);
    out_item_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.byte_count = 6'(cnt);
    r.status = st;
    r.last = 1'b1;
    results_due.push_back(r);
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.kind = KIND_DATA;
    r.out_byte = b;
    results_due.push_back(r);
  endfunction

  function automatic int find_held(input logic [KEY_W-1:0] key);
    int j;
    for (j = 0; j < MAX_FILES; j++) begin
      if (held[j] && held_key[j] == key) return j;
    end
    return -1;
  endfunction

  task automatic apply_table_item(input in_item_t it);
    logic [KEY_W-1:0] key;
    int nlen;
    int slot;
    int n;
    int j;
    key = '0;
    nlen = 0;
    while (nlen < KEY_BYTES && it.name_key[8*nlen +: 8] != 8'd0) begin
      key[8*nlen +: 8] = it.name_key[8*nlen +: 8];
      nlen++;
    end
    case (it.action)
      ACT_START: begin
        wr_busy = 1'b0;
        if (nlen >= NAME_MAX) begin
          queue_status(ST_NAME_LONG, 0);
        end else if (it.length >= DATA_MAX) begin
          queue_status(ST_LEN_LONG, 0);
        end else begin
          slot = find_held(key);
          for (j = 0; j < MAX_FILES; j++) begin
            if (slot < 0 && !held[j]) slot = j;
          end
          if (slot < 0) begin
            queue_status(ST_FULL, 0);
          end else begin
            held_key[slot] = key;
            if (it.length == 8'd0) begin
              held[slot] = 1'b1;
              held_len[slot] = '0;
              queue_status(ST_OK, 0);
            end else begin
              wr_busy = 1'b1;
              wr_idx = slot;
              wr_at = 0;
              wr_left = int'(it.length);
            end
          end
        end
      end
      ACT_DATA: begin
        if (!wr_busy) begin
          queue_status(ST_UNEXPECTED, 0);
        end else begin
          rec_mem[wr_idx][wr_at] = it.data_byte;
          wr_at++;
          wr_left--;
          if (wr_left == 0) begin
            wr_busy = 1'b0;
            held[wr_idx] = 1'b1;
            held_len[wr_idx] = 6'(wr_at);
            queue_status(ST_OK, wr_at);
          end
        end
      end
      ACT_READ: begin
        if (it.max_len == 8'd0) begin
          queue_status(ST_BAD_MAXLEN, 0);
        end else begin
          slot = find_held(key);
          if (slot < 0) begin
            queue_status(ST_NOT_FOUND, 0);
          end else begin
            n = int'(held_len[slot]);
            if (n > int'(it.max_len) - 1) n = int'(it.max_len) - 1;
            if (n > DATA_MAX - 1) n = DATA_MAX - 1;
            for (j = 0; j < n; j++) begin
              queue_byte(rec_mem[slot][j]);
            end
            queue_status(ST_OK, n);
          end
        end
      end
      default: begin
        for (j = 0; j < MAX_FILES; j++) begin
          held[j] = 1'b0;
          held_key[j] = '0;
          held_len[j] = '0;
        end
        wr_busy = 1'b0;
        wr_idx = 0;
        wr_at = 0;
        wr_left = 0;
        queue_status(ST_OK, 0);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      apply_table_item(in_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sink_wait_left = snk_idle_en ? $urandom_range(0, 6) : 0;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", out_data));
      end else begin
        next_due = results_due.pop_front();
        if (out_data.kind !== next_due.kind)
          report_mismatch($sformatf("kind %0d, wanted %0d", out_data.kind, next_due.kind));
        if (out_data.out_byte !== next_due.out_byte)
          report_mismatch($sformatf("out_byte %h, wanted %h",
                                    out_data.out_byte, next_due.out_byte));
        if (out_data.byte_count !== next_due.byte_count)
          report_mismatch($sformatf("byte_count %0d, wanted %0d",
                                    out_data.byte_count, next_due.byte_count));
        if (out_data.status !== next_due.status)
          report_mismatch($sformatf("status %0d, wanted %0d",
                                    out_data.status, next_due.status));
        if (out_data.last !== next_due.last)
          report_mismatch($sformatf("last %0d, wanted %0d", out_data.last, next_due.last));
      end
    end
  end

  // The long hold is counted here so the sender can keep offering transactions meanwhile.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles_left > 0) begin
        out_stall <= 1'b1;
        hold_cycles_left--;
      end else if (sink_wait_left > 0) begin
        out_stall <= 1'b1;
        sink_wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic start_write(input logic [63:0] key, input logic [7:0] len);
    in_item_t it;
    it.action = ACT_START;
    it.name_key = key;
    it.length = len;
    it.max_len = 8'($urandom_range(0, 255));
    it.data_byte = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic put_byte(input logic [7:0] b);
    in_item_t it;
    it.action = ACT_DATA;
    it.name_key = {$urandom, $urandom};
    it.length = 8'($urandom_range(0, 255));
    it.max_len = 8'($urandom_range(0, 255));
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic read_name(input logic [63:0] key, input logic [7:0] ml);
    in_item_t it;
    it.action = ACT_READ;
    it.name_key = key;
    it.length = 8'($urandom_range(0, 255));
    it.max_len = ml;
    it.data_byte = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic clear_all();
    in_item_t it;
    it.action = ACT_CLEAR;
    it.name_key = {$urandom, $urandom};
    it.length = 8'($urandom_range(0, 255));
    it.max_len = 8'($urandom_range(0, 255));
    it.data_byte = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Bytes after the terminating zero must be ignored, so fill them with noise now and then.
  function automatic logic [63:0] with_garbage(input logic [63:0] key);
    int n;
    logic [63:0] g;
    n = 0;
    while (n < 8 && key[8*n +: 8] != 8'd0) n++;
    if (n < 7 && $urandom_range(0, 1) == 1) begin
      g = {$urandom, $urandom};
      key = key | (g << (8 * (n + 1)));
    end
    return key;
  endfunction

  function automatic logic [63:0] overlong_name();
    logic [63:0] k;
    int b;
    for (b = 0; b < 8; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  task automatic test_error_codes();
    read_name(KEY_A, 8'd10);
    read_name(KEY_A, 8'd0);
    put_byte(8'hA5);
    start_write(KEY_OVER, 8'd3);
    start_write(64'h8001_0203_0405_0607, 8'd200);
    start_write(KEY_A, 8'd64);
    start_write(KEY_A, 8'd255);
    put_byte(8'h5A);
    read_name(KEY_OVER, 8'd255);
    wait_results_drained();
  endtask

  task automatic test_write_and_read();
    start_write(KEY_EMPTY, 8'd0);
    read_name(KEY_EMPTY, 8'd255);
    start_write(KEY_A, 8'd3);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h5A);
    read_name(64'hFFFF_FFFF_FFFF_0061, 8'd255);
    read_name(KEY_A, 8'd1);
    read_name(KEY_A, 8'd2);
    read_name(KEY_A, 8'd4);
    start_write(KEY_B, 8'd1);
    put_byte(8'h80);
    read_name(KEY_B, 8'd255);
    wait_results_drained();
  endtask

  task automatic test_open_write_cases();
    start_write(KEY_C, 8'd3);
    put_byte(8'h11);
    start_write(KEY_D, 8'd2);
    put_byte(8'h22);
    read_name(KEY_C, 8'd255);
    read_name(KEY_D, 8'd255);
    put_byte(8'h33);
    read_name(KEY_D, 8'd255);
    start_write(KEY_A, 8'd5);
    put_byte(8'h44);
    put_byte(8'h55);
    read_name(KEY_A, 8'd255);
    put_byte(8'h66);
    put_byte(8'h77);
    put_byte(8'h88);
    read_name(KEY_A, 8'd255);
    start_write(KEY_A, 8'd2);
    put_byte(8'h99);
    start_write(KEY_OVER, 8'd2);
    put_byte(8'h01);
    start_write(KEY_B, 8'd4);
    put_byte(8'hAA);
    clear_all();
    put_byte(8'hBB);
    read_name(KEY_A, 8'd255);
    wait_results_drained();
  endtask

  task automatic test_table_full();
    int i;
    for (i = 0; i < MAX_FILES; i++) begin
      if (i % 2 == 0) begin
        start_write(64'h30 + i, 8'd0);
      end else begin
        start_write(64'h30 + i, 8'd1);
        put_byte(8'(8'hC0 + i));
      end
    end
    start_write(64'h40, 8'd0);
    start_write(64'h33, 8'd0);
    read_name(64'h33, 8'd255);
    read_name(64'h37, 8'd255);
    clear_all();
    read_name(64'h30, 8'd255);
    wait_results_drained();
  endtask

  task automatic test_longest_record();
    int i;
    start_write(KEY_LONG, 8'd63);
    for (i = 0; i < DATA_MAX - 1; i++) put_byte(8'($urandom_range(0, 255)));
    read_name(KEY_LONG, 8'd255);
    read_name(KEY_LONG, 8'd64);
    read_name(KEY_LONG, 8'd63);
    wait_results_drained();
  endtask

  task automatic test_output_backpressure();
    src_idle_en = 1'b0;
    hold_cycles_left = 300;
    repeat (6) read_name(KEY_LONG, 8'd255);
    src_idle_en = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    logic [63:0] pool [12];
    int sent;
    int seq;
    int k;
    int b;
    int nl;
    int len;
    int cut;
    int r;
    int ml;
    for (k = 0; k < 12; k++) begin
      pool[k] = '0;
      nl = $urandom_range(0, NAME_MAX - 1);
      for (b = 0; b < nl; b++) pool[k][8*b +: 8] = 8'($urandom_range(1, 255));
    end
    sent = 0;
    seq = 0;
    while (sent < 75) begin
      if (seq % 10 == 0) begin
        src_idle_en = ($urandom_range(0, 2) != 0);
        snk_idle_en = ($urandom_range(0, 2) != 0);
      end
      seq++;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 11);
      if (r < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 63) : $urandom_range(0, 6);
        start_write(with_garbage(pool[k]), 8'(len));
        for (b = 0; b < len; b++) put_byte(8'($urandom_range(0, 255)));
        sent += len + 1;
      end else if (r < 80) begin
        case ($urandom_range(0, 9))
          0: ml = 0;
          1: ml = $urandom_range(64, 255);
          default: ml = $urandom_range(1, 12);
        endcase
        read_name(with_garbage(pool[k]), 8'(ml));
        sent++;
      end else if (r < 84) begin
        clear_all();
        sent++;
      end else if (r < 90) begin
        len = $urandom_range(2, 8);
        cut = $urandom_range(0, len - 1);
        start_write(with_garbage(pool[k]), 8'(len));
        for (b = 0; b < cut; b++) put_byte(8'($urandom_range(0, 255)));
        sent += cut + 1;
      end else if (r < 94) begin
        put_byte(8'($urandom_range(0, 255)));
        sent++;
      end else if (r < 97) begin
        start_write(overlong_name(), 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        start_write(with_garbage(pool[k]), 8'($urandom_range(64, 255)));
        sent++;
      end
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  initial begin
    int s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    for (s = 0; s < MAX_FILES; s++) begin
      held[s] = 1'b0;
      held_key[s] = '0;
      held_len[s] = '0;
    end
    wr_busy = 1'b0;
    wr_idx = 0;
    wr_at = 0;
    wr_left = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_error_codes();
    test_write_and_read();
    test_open_write_cases();
    test_table_full();
    test_longest_record();
    test_output_backpressure();
    test_random_traffic();

    wait_results_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nfts_pkg.sv
rtl/nfts_ram.sv
rtl/nfts_outreg.sv
rtl/nfts_ctrl.sv
rtl/named_file_table_store_top.sv
dv/named_file_table_store_top_tb.sv
